@@ rtl/sadpcm_pkg.sv @@
// Shared types, constants and the coefficient table of the stereo ADPCM decoder.
// Used by sadpcm_ctrl, sadpcm_dp and the top level; no dependencies.
`default_nettype none

package sadpcm_pkg;

    // Frame layout: left header, 8 left data bytes, right header, 8 right data bytes
    localparam logic [4:0] FRAME_LAST    = 5'd17;
    localparam logic [4:0] LEFT_HDR_POS  = 5'd0;
    localparam logic [4:0] RIGHT_HDR_POS = 5'd9;

    // Prediction scale: (c1*newest + c2*older) >>> PRED_SHIFT
    localparam int PRED_SHIFT = 11;

    typedef logic signed [13:0] t_coef;
    typedef logic signed [15:0] t_sample;

    typedef struct packed {
        t_coef c1;
        t_coef c2;
    } t_coef_pair;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_HI,
        S_ACC_HI,
        S_MUL_LO,
        S_ACC_LO
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;       // latch the input byte
        logic clr_hist;  // clear both channel histories
        logic ld_lhdr;   // load left header from the input byte
        logic ld_rhdr;   // load right header from the input byte
        logic mul;       // form both prediction products
        logic acc;       // finish a sample, load output, shift history
        logic sel_lo;    // work on the low nibble
        logic chan;      // 0 left, 1 right
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a sample this cycle
    } t_dp_sts;

    // Predictor coefficient pairs selected by the header low nibble
    function automatic t_coef_pair coef_lookup(input logic [3:0] sel);
        t_coef_pair p;
        case (sel)
            4'd0:    p = '{c1:  14'sd0,    c2:  14'sd0};
            4'd1:    p = '{c1:  14'sd2048, c2:  14'sd0};
            4'd2:    p = '{c1:  14'sd0,    c2:  14'sd2048};
            4'd3:    p = '{c1:  14'sd1024, c2:  14'sd1024};
            4'd4:    p = '{c1:  14'sd4096, c2: -14'sd2048};
            4'd5:    p = '{c1:  14'sd3584, c2: -14'sd1536};
            4'd6:    p = '{c1:  14'sd3072, c2: -14'sd1024};
            4'd7:    p = '{c1:  14'sd4608, c2: -14'sd2560};
            4'd8:    p = '{c1:  14'sd4200, c2: -14'sd2248};
            4'd9:    p = '{c1:  14'sd4800, c2: -14'sd2300};
            4'd10:   p = '{c1:  14'sd5120, c2: -14'sd3072};
            4'd11:   p = '{c1:  14'sd2048, c2: -14'sd2048};
            4'd12:   p = '{c1:  14'sd1024, c2: -14'sd1024};
            4'd13:   p = '{c1: -14'sd1024, c2:  14'sd1024};
            4'd14:   p = '{c1: -14'sd1024, c2:  14'sd0};
            4'd15:   p = '{c1: -14'sd2048, c2:  14'sd0};
            default: p = '{c1:  14'sd0,    c2:  14'sd0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/stereo_4bit_adpcm_block_decoder.sv @@
// Stereo 4-bit ADPCM block decoder, top level.
// Depends on sadpcm_pkg, sadpcm_ctrl and sadpcm_dp.
//
// Input stream (s_axis): one byte per transfer in tdata, restart flag in tuser.
// Bytes form 18-byte frames: left header, 8 left data bytes, right header,
// 8 right data bytes. Restart clears both histories and takes its byte as
// the left header of a new frame.
// Output stream (m_axis): one decoded sample per transfer; tuser is the
// channel, tlast marks the low-nibble (second) sample of a data byte.
// Timing: a header byte yields nothing and leaves the decoder ready. A data
// byte passes MUL_HI, ACC_HI, MUL_LO and ACC_LO; each ACC state loads one
// sample into the output register, high nibble first. Each sample uses the
// shared pair of predictor multipliers in its MUL state and sums, shifts and
// updates history in its ACC state; the second sample waits for the first's history.
// The output register lets the next byte be accepted while the last sample
// still waits. When the receiver stalls, the decoder holds the pending sample
// work until the output register frees.
// Reset (i_rst_n low, synchronous) clears headers, histories, frame position
// and the output valid.
`default_nettype none

module stereo_4bit_adpcm_block_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] restart
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample
    output logic             m_axis_tuser,   // [0] channel
    output logic             m_axis_tlast
);
    import sadpcm_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sadpcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_restart  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sadpcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_byte      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sample    (m_axis_tdata),
        .o_chan      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/sadpcm_ctrl.sv @@
// Controller of the stereo ADPCM decoder: frame position, channel and sample sequencing.
// Depends on sadpcm_pkg; drives sadpcm_dp through t_dp_cmd.
`default_nettype none

module sadpcm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_restart,
    output logic                     o_in_ready,
    input  wire sadpcm_pkg::t_dp_sts i_sts,
    output sadpcm_pkg::t_dp_cmd      o_cmd
);
    import sadpcm_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_pos, n_pos;
    logic       r_chan, n_chan;
    logic [4:0] w_pos;

    // Position of the byte now offered; restart starts a new frame
    assign w_pos = i_restart ? LEFT_HDR_POS : r_pos;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= LEFT_HDR_POS;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_chan  <= n_chan;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_chan     = r_chan;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap      = 1'b1;
                    o_cmd.clr_hist = i_restart;
                    n_pos = (w_pos == FRAME_LAST) ? 5'd0 : w_pos + 5'd1;
                    if (w_pos == LEFT_HDR_POS) begin
                        o_cmd.ld_lhdr = 1'b1;
                    end else if (w_pos == RIGHT_HDR_POS) begin
                        o_cmd.ld_rhdr = 1'b1;
                    end else begin
                        n_chan  = (w_pos > RIGHT_HDR_POS);
                        n_state = S_MUL_HI;
                    end
                end
            end
            S_MUL_HI: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC_HI;
            end
            S_ACC_HI: begin
                if (i_sts.out_free) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul    = 1'b1;
                o_cmd.sel_lo = 1'b1;
                n_state      = S_ACC_LO;
            end
            S_ACC_LO: begin
                o_cmd.sel_lo = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Frame position always stays inside the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_LAST)
        else $error("frame position out of range");

    // A sample is only finished when the output register can take it
    a_acc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |-> i_sts.out_free)
        else $error("sample finished into a full output register");

    // Header bytes produce no work and leave the controller ready
    a_hdr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.ld_lhdr || o_cmd.ld_rhdr) |=> r_state == S_IDLE)
        else $error("header byte started sample work");

endmodule

`default_nettype wire

@@ rtl/sadpcm_dp.sv @@
// Datapath of the stereo ADPCM decoder: headers, histories, predictor and output register.
// Depends on sadpcm_pkg; commanded by sadpcm_ctrl.
`default_nettype none

module sadpcm_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sadpcm_pkg::t_dp_cmd i_cmd,
    output sadpcm_pkg::t_dp_sts      o_sts,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [15:0]              o_sample,
    output logic                     o_chan,
    output logic                     o_last
);
    import sadpcm_pkg::*;

    logic [7:0]         r_byte;
    logic [7:0]         r_lhdr, r_rhdr;
    t_sample            r_lnew, r_lold, r_rnew, r_rold;
    logic signed [29:0] r_prod1, r_prod2;
    logic               r_out_valid;
    logic [15:0]        r_out_sample;
    logic               r_out_chan, r_out_last;

    logic [7:0]         w_hdr;
    t_coef_pair         w_coef;
    t_sample            w_new, w_old;
    logic signed [29:0] w_prod1, w_prod2;
    logic signed [30:0] w_sum;
    logic [3:0]         w_nib;
    logic [15:0]        w_nib_ext, w_scaled, w_pred, w_sample;

    // Channel selection of header and history
    assign w_hdr  = i_cmd.chan ? r_rhdr : r_lhdr;
    assign w_coef = coef_lookup(w_hdr[3:0]);
    assign w_new  = i_cmd.chan ? r_rnew : r_lnew;
    assign w_old  = i_cmd.chan ? r_rold : r_lold;

    // Prediction products
    assign w_prod1 = w_coef.c1 * w_new;
    assign w_prod2 = w_coef.c2 * w_old;

    // Prediction sum, floor shift, scaled code; all wrap to 16 bits
    assign w_sum     = 31'(r_prod1) + 31'(r_prod2);
    assign w_pred    = w_sum[PRED_SHIFT+15:PRED_SHIFT];
    assign w_nib     = i_cmd.sel_lo ? r_byte[3:0] : r_byte[7:4];
    assign w_nib_ext = {{12{w_nib[3]}}, w_nib};
    assign w_scaled  = w_nib_ext << w_hdr[7:4];
    assign w_sample  = w_scaled + w_pred;

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Input byte and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_byte <= i_byte;
        end
        if (i_cmd.mul) begin
            r_prod1 <= w_prod1;
            r_prod2 <= w_prod2;
        end
    end

    // Headers and channel histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lhdr <= '0;
            r_rhdr <= '0;
            r_lnew <= '0;
            r_lold <= '0;
            r_rnew <= '0;
            r_rold <= '0;
        end else begin
            if (i_cmd.ld_lhdr) begin
                r_lhdr <= i_byte;
            end
            if (i_cmd.ld_rhdr) begin
                r_rhdr <= i_byte;
            end
            if (i_cmd.clr_hist) begin
                r_lnew <= '0;
                r_lold <= '0;
                r_rnew <= '0;
                r_rold <= '0;
            end else if (i_cmd.acc) begin
                if (i_cmd.chan) begin
                    r_rold <= r_rnew;
                    r_rnew <= w_sample;
                end else begin
                    r_lold <= r_lnew;
                    r_lnew <= w_sample;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_out_sample <= w_sample;
            r_out_chan   <= i_cmd.chan;
            r_out_last   <= i_cmd.sel_lo;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_chan      = r_out_chan;
    assign o_last      = r_out_last;

    // Restart leaves both histories at zero
    a_clr_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_hist |=> (r_lnew == '0 && r_lold == '0 && r_rnew == '0 && r_rold == '0))
        else $error("history not cleared on restart");

    // A finished sample is presented in the next cycle
    a_acc_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |=> r_out_valid)
        else $error("finished sample not presented");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for stereo_4bit_adpcm_block_decoder: byte stream in, PCM samples out.
// Depends on sadpcm_pkg (frame positions, prediction shift) and the decoder RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sadpcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_PRINTED    = 30;

    // DUT ports, all inputs known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] sample
    logic        m_axis_tuser;            // [0] channel
    logic        m_axis_tlast;            // low-nibble (second) sample

    typedef struct packed {
        logic [15:0] sample;
        logic        chan;
        logic        second;
    } t_pcm;

    t_pcm pcm_expected[$];

    // Decoder mirror state
    logic [4:0]  dec_pos = '0;
    logic [7:0]  dec_lhdr = '0;
    logic [7:0]  dec_rhdr = '0;
    logic [15:0] dec_newest [2] = '{16'h0, 16'h0};
    logic [15:0] dec_older  [2] = '{16'h0, 16'h0};

    // Stimulus-side frame position, used only to pick header or data content
    int tx_pos = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int bytes_in       = 0;
    int restarts_in    = 0;
    int samples_out    = 0;
    int idle_cycles    = 0;

    stereo_4bit_adpcm_block_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One sample: nibble scaled by shift plus floor-shifted two-tap prediction, wrapped
    function automatic logic [15:0] adpcm_sample(input logic [7:0] hdr, input logic [3:0] code,
                                                 input logic [15:0] newest,
                                                 input logic [15:0] older);
        longint c1;
        longint c2;
        longint acc;
        longint val;
        logic signed [3:0]  nib;
        logic signed [15:0] nws;
        logic signed [15:0] ols;
        case (hdr[3:0])
            4'd0:    begin c1 = 0;     c2 = 0;     end
            4'd1:    begin c1 = 2048;  c2 = 0;     end
            4'd2:    begin c1 = 0;     c2 = 2048;  end
            4'd3:    begin c1 = 1024;  c2 = 1024;  end
            4'd4:    begin c1 = 4096;  c2 = -2048; end
            4'd5:    begin c1 = 3584;  c2 = -1536; end
            4'd6:    begin c1 = 3072;  c2 = -1024; end
            4'd7:    begin c1 = 4608;  c2 = -2560; end
            4'd8:    begin c1 = 4200;  c2 = -2248; end
            4'd9:    begin c1 = 4800;  c2 = -2300; end
            4'd10:   begin c1 = 5120;  c2 = -3072; end
            4'd11:   begin c1 = 2048;  c2 = -2048; end
            4'd12:   begin c1 = 1024;  c2 = -1024; end
            4'd13:   begin c1 = -1024; c2 = 1024;  end
            4'd14:   begin c1 = -1024; c2 = 0;     end
            default: begin c1 = -2048; c2 = 0;     end
        endcase
        nib = code;
        nws = newest;
        ols = older;
        acc = c1 * longint'(nws) + c2 * longint'(ols);
        val = (longint'(nib) <<< hdr[7:4]) + (acc >>> PRED_SHIFT);
        return val[15:0];
    endfunction

    // Decode one nibble on a channel, queue the sample, advance that channel's history
    task automatic queue_sample(input logic [7:0] hdr, input logic [3:0] code,
                                input logic ch, input logic second);
        t_pcm s;
        s.sample = adpcm_sample(hdr, code, dec_newest[ch], dec_older[ch]);
        s.chan   = ch;
        s.second = second;
        dec_older[ch]  = dec_newest[ch];
        dec_newest[ch] = s.sample;
        pcm_expected.push_back(s);
    endtask

    // Mirror of the decoder for one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic restart);
        logic [4:0] pos;
        logic       ch;
        logic [7:0] hdr;
        if (restart) begin
            dec_newest = '{16'h0, 16'h0};
            dec_older  = '{16'h0, 16'h0};
            dec_pos    = LEFT_HDR_POS;
            restarts_in++;
        end
        pos = dec_pos;
        dec_pos = (pos == FRAME_LAST) ? LEFT_HDR_POS : pos + 5'd1;
        if (pos == LEFT_HDR_POS) begin
            dec_lhdr = b;
        end else if (pos == RIGHT_HDR_POS) begin
            dec_rhdr = b;
        end else begin
            ch  = (pos > RIGHT_HDR_POS);
            hdr = ch ? dec_rhdr : dec_lhdr;
            queue_sample(hdr, b[7:4], ch, 1'b0);
            queue_sample(hdr, b[3:0], ch, 1'b1);
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Input monitor: predict on every accepted byte
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            bytes_in++;
            decode_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    // Output side: compare each accepted sample, then pick the next ready
    always @(posedge i_clk) begin
        t_pcm want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            samples_out++;
            if (pcm_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h ch %0d last %0d",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = pcm_expected.pop_front();
                if (m_axis_tdata !== want.sample || m_axis_tuser !== want.chan ||
                    m_axis_tlast !== want.second)
                    report_mismatch($sformatf("got %h/%0d/%0d want %h/%0d/%0d",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast,
                                              want.sample, want.chan, want.second));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Send one byte; returns just after the edge that accepted it
    task automatic send_byte(input logic [7:0] b, input logic restart);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tx_pos = (restart || tx_pos >= 17) ? (restart ? 1 : 0) : tx_pos + 1;
    endtask

    // Drop valid and hold until every queued sample has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pcm_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Frames with random headers and data; a few restarts land anywhere in a frame
    task automatic run_stream(input int count);
        logic [7:0] b;
        logic       rs;
        for (int i = 0; i < count; i++) begin
            rs = ($urandom_range(99) < 3);
            if (rs || tx_pos == 0 || tx_pos == 9) begin
                b = 8'($urandom_range(255));
                // keep shifts small half the time so history drives the output
                if ($urandom_range(1) == 0)
                    b[7:4] = 4'($urandom_range(4));
            end else begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, rs);
        end
    endtask

    // Extreme shifts and codes, frame wrap, restart in mid-frame
    task automatic test_directed();
        logic [7:0] seq [24] = '{
            8'hF8, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'h88, 8'h77, 8'h17, 8'hE1,
            8'h0F, 8'h7F, 8'h80, 8'h01, 8'hF0, 8'h77, 8'h77, 8'h88, 8'h99,
            8'hA4, 8'h7F, 8'h7F,
            8'h31, 8'h80, 8'h08};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 24; i++)
            send_byte(seq[i], (i == 0) || (i == 21));
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_stream(500);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        run_stream(450);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        run_stream(450);
    endtask

    task automatic test_mixed_idle();
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_stream(480);
    endtask

    // Sender stops until the output has fully caught up, then resumes
    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        run_stream(25);
        wait_drained();
        run_stream(25);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d stream bytes (%0d with restart) and %0d decoded samples,",
                 bytes_in, restarts_in, samples_out);
        $display("under no idling, sender gaps, receiver stalls, both, and a full drain");
        if (errors == 0 && pcm_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
